@@ hw/rtl/osst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osst_pkg: shared types and codes for the ordered set store
// Item layouts, operation and status codes, and the control word that the
// sequencer broadcasts to the storage row.
// ----------------------------------------------------------------------------
package osst_pkg;

  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int REF_W   = 32;
  localparam int STAT_W  = 2;
  localparam int FIDX_W  = 5;
  localparam int CNT_W   = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT_AT    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_AT      = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND         = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR        = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [REF_W-1:0] node_ref;
  } osst_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] found_index;
    logic [REF_W-1:0]  node_value;
    logic [CNT_W-1:0]  entry_count;
  } osst_out_t;

  // broadcast to every storage slot
  typedef struct packed {
    logic cmp_en;  // capture key compare
    logic ins;     // open a hole at target, load key there
    logic del;     // close the hole at target
  } osst_ctrl_t;

endpackage

@@ hw/rtl/osst_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osst_cell: one slot of the ordered list
// Holds one entry, compares it with the broadcast key and moves data to or
// from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module osst_cell #(
  parameter int DEPTH    = 32,
  parameter int REF_BITS = 32,
  parameter int INDEX    = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  osst_pkg::osst_ctrl_t         ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]   tgt,
  input  logic [$clog2(DEPTH+1)-1:0]   cnt,
  input  logic [REF_BITS-1:0]          key,
  input  logic [REF_BITS-1:0]          below,
  input  logic [REF_BITS-1:0]          above,
  output logic [REF_BITS-1:0]          entry,
  output logic                         match,
  output logic [REF_BITS-1:0]          rd_word
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] IDX = CW'(INDEX);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (IDX > tgt) begin
        entry <= below;
      end else if (IDX == tgt) begin
        entry <= key;
      end
    end else if (ctrl.del) begin
      if (IDX >= tgt) begin
        entry <= above;
      end
    end
  end

  // only live slots may report a hit
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.cmp_en) begin
      match <= (IDX < cnt) && (entry == key);
    end
  end

  assign rd_word = (IDX == tgt) ? entry : '0;

endmodule

@@ hw/rtl/ordered_set_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_set_store: ordered list of nonzero references with duplicate check
// Row of storage slots driven by a four-step sequencer; one result per item.
// ----------------------------------------------------------------------------
// Each input item passes through accept, a compare of the key in every slot
// at once, a lowest-match encode over the registered hit flags, and the update
// step in which every slot shifts toward or away from the target together
// while the result is loaded into the output register. The next item is
// accepted the cycle after the update, so a new item waits until the last one
// is through. The update waits while the output register still holds a result
// that has not been taken. The list holds up to DEPTH entries; adds beyond
// that report status full. Entries at or above the live count are never read,
// so the store needs no clearing after reset and clear only zeroes the count.
// check_duplicates resets to 1 and is written through cfg_we / cfg_wdata; the
// user must write it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module ordered_set_store #(
  parameter int DEPTH    = 32,
  parameter int REF_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  osst_pkg::osst_in_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output osst_pkg::osst_out_t  out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);

  localparam int CW = $clog2(DEPTH + 1);
  // wide enough to compare an input position against the count
  localparam int XW = ((CW > osst_pkg::POS_W) ? CW : osst_pkg::POS_W) + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_LOC  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0]            state;
  osst_pkg::osst_in_t    req;
  logic [CW-1:0]         count;
  logic                  check_dup;
  logic                  hit;
  logic [CW-1:0]         hit_idx;

  logic [REF_BITS-1:0]   key;
  logic                  ref_nz;
  logic [DEPTH-1:0]      match_w;
  logic [DEPTH-1:0]      lowest;
  logic [CW-1:0]         hit_idx_next;
  logic [REF_BITS-1:0]   entry_w [DEPTH];
  logic [REF_BITS-1:0]   rd_w    [DEPTH];
  logic [REF_BITS-1:0]   sel_word;
  logic [CW-1:0]         tgt;
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         cnt_x;
  logic                  exec_go;
  osst_pkg::osst_ctrl_t  ctrl;

  logic                         do_ins;
  logic                         do_del;
  logic [CW-1:0]                count_next;
  logic [osst_pkg::STAT_W-1:0]  status_next;
  logic [osst_pkg::FIDX_W-1:0]  found_next;
  logic [osst_pkg::REF_W-1:0]   value_next;

  assign key     = REF_BITS'(req.node_ref);
  assign ref_nz  = (key != '0);
  assign pos_x   = XW'(req.position);
  assign cnt_x   = XW'(count);
  assign in_ready = (state == S_IDLE);
  assign exec_go  = (state == S_EXEC) && (!out_valid || out_ready);

  // target slot: append goes at the tail, value searches use the encoded hit
  always_comb begin
    case (req.operation)
      osst_pkg::OP_APPEND:       tgt = count;
      osst_pkg::OP_REMOVE_VALUE: tgt = hit_idx;
      osst_pkg::OP_FIND:         tgt = hit_idx;
      default:                   tgt = CW'(req.position);
    endcase
  end

  // ---- storage row ---------------------------------------------------------
  assign ctrl.cmp_en = (state == S_CMP);
  assign ctrl.ins    = exec_go && do_ins;
  assign ctrl.del    = exec_go && do_del;

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic [REF_BITS-1:0] below_w;
    logic [REF_BITS-1:0] above_w;
    if (i == 0) begin : g_lo
      assign below_w = '0;
    end else begin : g_lo
      assign below_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign above_w = '0;
    end else begin : g_hi
      assign above_w = entry_w[i+1];
    end
    osst_cell #(
      .DEPTH    (DEPTH),
      .REF_BITS (REF_BITS),
      .INDEX    (i)
    ) u_slot (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .tgt     (tgt),
      .cnt     (count),
      .key     (key),
      .below   (below_w),
      .above   (above_w),
      .entry   (entry_w[i]),
      .match   (match_w[i]),
      .rd_word (rd_w[i])
    );
  end

  // only the target slot drives a nonzero word
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_word = sel_word | rd_w[i];
    end
  end

  // ---- lowest-match encode -------------------------------------------------
  // isolate the lowest set hit flag, then OR together its index
  assign lowest = match_w & (~match_w + DEPTH'(1));

  always_comb begin
    hit_idx_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) begin
        hit_idx_next = hit_idx_next | CW'(i);
      end
    end
  end

  // ---- operation decode ----------------------------------------------------
  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    count_next  = count;
    status_next = osst_pkg::ST_REJECT;
    found_next  = '0;
    value_next  = '0;
    case (req.operation)
      osst_pkg::OP_APPEND, osst_pkg::OP_INSERT_AT: begin
        // null and bad position first, then duplicate, then full
        if (!ref_nz ||
            ((req.operation == osst_pkg::OP_INSERT_AT) && (pos_x > cnt_x))) begin
          status_next = osst_pkg::ST_REJECT;
        end else if (check_dup && hit) begin
          status_next = osst_pkg::ST_REJECT;
        end else if (count == FULL_CNT) begin
          status_next = osst_pkg::ST_FULL;
        end else begin
          do_ins      = 1'b1;
          count_next  = count + CW'(1);
          status_next = osst_pkg::ST_DONE;
        end
      end
      osst_pkg::OP_REMOVE_AT: begin
        if (pos_x < cnt_x) begin
          do_del      = 1'b1;
          count_next  = count - CW'(1);
          value_next  = osst_pkg::REF_W'(sel_word);
          status_next = osst_pkg::ST_DONE;
        end
      end
      osst_pkg::OP_REMOVE_VALUE: begin
        if (ref_nz && hit) begin
          do_del      = 1'b1;
          count_next  = count - CW'(1);
          value_next  = osst_pkg::REF_W'(sel_word);
          status_next = osst_pkg::ST_DONE;
        end
      end
      osst_pkg::OP_READ_AT: begin
        if (pos_x < cnt_x) begin
          value_next  = osst_pkg::REF_W'(sel_word);
          status_next = osst_pkg::ST_DONE;
        end
      end
      osst_pkg::OP_FIND: begin
        if (ref_nz && hit) begin
          found_next  = osst_pkg::FIDX_W'(hit_idx);
          status_next = osst_pkg::ST_DONE;
        end
      end
      osst_pkg::OP_CLEAR: begin
        count_next  = '0;
        status_next = osst_pkg::ST_DONE;
      end
      default: begin
        status_next = osst_pkg::ST_REJECT;
      end
    endcase
  end

  // ---- sequencer and control state -----------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      check_dup <= 1'b1;
      out_valid <= 1'b0;
      hit       <= 1'b0;
      hit_idx   <= '0;
    end else begin
      if (cfg_we) begin
        check_dup <= cfg_wdata;
      end
      // a result taken in the update cycle is replaced by the new one
      if (out_valid && out_ready && !exec_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_LOC;
        end
        S_LOC: begin
          hit     <= |match_w;
          hit_idx <= hit_idx_next;
          state   <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            count     <= count_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_item;
    end
    if (exec_go) begin
      out_item.status      <= status_next;
      out_item.found_index <= found_next;
      out_item.node_value  <= value_next;
      out_item.entry_count <= osst_pkg::CNT_W'(count_next);
    end
  end

  // ---- assertions ----------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list by one");

  a_full_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == osst_pkg::ST_FULL) |-> count == FULL_CNT)
    else $error("full reported on a list that is not full");

  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> state == S_IDLE && out_valid)
    else $error("update step did not deliver a result");

endmodule

@@ test/tb_ordered_set_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_set_store: self-checking bench for the ordered set store
// Drives list operations through the valid/ready input channel and mirrors
// the list in a local shadow copy. Every returned item is checked field by
// field against the shadow's prediction. Runs directed corner cases, a full
// list, duplicate checking on and off, random traffic with idling on both
// sides, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_ordered_set_store;

  localparam int DEPTH       = 32;
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 300;   // long output hold-off
  localparam int MAX_GAP     = 40;    // cap on one sender idle stretch
  localparam int TAIL_CYCLES = 20;    // quiet window after the last result

  // op code 7 has no meaning; the block must refuse it
  localparam logic [osst_pkg::OP_W-1:0] OP_UNDEFINED = 3'd7;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  osst_pkg::osst_in_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  osst_pkg::osst_out_t out_item;
  logic                cfg_we    = 1'b0;
  logic                cfg_wdata = 1'b0;

  ordered_set_store #(
    .DEPTH    (DEPTH),
    .REF_BITS (osst_pkg::REF_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow list: what the block should hold after every accepted item
  // --------------------------------------------------------------------------
  logic [osst_pkg::REF_W-1:0] list_shadow [DEPTH];
  int                         shadow_count;
  logic                       dup_check_on;
  logic [osst_pkg::REF_W-1:0] key_pool [8];

  // predicted results, oldest first
  osst_pkg::osst_out_t pending_results [$];

  // idling knobs, in percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // hold-off requests; the receiver process counts the hold itself
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  int error_count   = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int quiet_cycles  = 0;
  int status_tally [4] = '{default: 0};

  // lowest position holding key, -1 if none (null is never stored)
  function automatic int lowest_match(input logic [osst_pkg::REF_W-1:0] key);
    int i;
    for (i = 0; i < shadow_count; i++)
      if (list_shadow[i] == key) return i;
    return -1;
  endfunction

  function automatic logic [osst_pkg::STAT_W-1:0] add_entry(
      input int pos, input logic [osst_pkg::REF_W-1:0] key);
    int i;
    // null, bad position and duplicate are checked ahead of fullness
    if (key == '0 || pos > shadow_count) return osst_pkg::ST_REJECT;
    if (dup_check_on && lowest_match(key) >= 0) return osst_pkg::ST_REJECT;
    if (shadow_count >= DEPTH) return osst_pkg::ST_FULL;
    for (i = shadow_count; i > pos; i--) list_shadow[i] = list_shadow[i-1];
    list_shadow[pos] = key;
    shadow_count++;
    return osst_pkg::ST_DONE;
  endfunction

  function automatic logic [osst_pkg::REF_W-1:0] drop_entry(input int pos);
    logic [osst_pkg::REF_W-1:0] v;
    int i;
    v = list_shadow[pos];
    for (i = pos + 1; i < shadow_count; i++) list_shadow[i-1] = list_shadow[i];
    shadow_count--;
    return v;
  endfunction

  // apply one item to the shadow list and return the result it must produce
  function automatic osst_pkg::osst_out_t apply_op(input osst_pkg::osst_in_t it);
    osst_pkg::osst_out_t r;
    int pos;
    int hit;
    r        = '0;
    r.status = osst_pkg::ST_REJECT;
    pos      = int'(it.position);
    hit      = lowest_match(it.node_ref);
    case (it.operation)
      osst_pkg::OP_APPEND:    r.status = add_entry(shadow_count, it.node_ref);
      osst_pkg::OP_INSERT_AT: r.status = add_entry(pos, it.node_ref);
      osst_pkg::OP_REMOVE_AT: begin
        if (pos < shadow_count) begin
          r.node_value = drop_entry(pos);
          r.status     = osst_pkg::ST_DONE;
        end
      end
      osst_pkg::OP_REMOVE_VALUE: begin
        if (it.node_ref != '0 && hit >= 0) begin
          r.node_value = drop_entry(hit);
          r.status     = osst_pkg::ST_DONE;
        end
      end
      osst_pkg::OP_READ_AT: begin
        if (pos < shadow_count) begin
          r.node_value = list_shadow[pos];
          r.status     = osst_pkg::ST_DONE;
        end
      end
      osst_pkg::OP_FIND: begin
        if (it.node_ref != '0 && hit >= 0) begin
          r.found_index = hit[osst_pkg::FIDX_W-1:0];
          r.status      = osst_pkg::ST_DONE;
        end
      end
      osst_pkg::OP_CLEAR: begin
        shadow_count = 0;
        r.status     = osst_pkg::ST_DONE;
      end
      default: ;  // undefined code: refused, list untouched
    endcase
    r.entry_count = shadow_count[osst_pkg::CNT_W-1:0];
    return r;
  endfunction

  // nonzero key that is not in the list right now
  function automatic logic [osst_pkg::REF_W-1:0] fresh_key();
    logic [osst_pkg::REF_W-1:0] k;
    do k = $urandom(); while (k == '0 || lowest_match(k) >= 0);
    return k;
  endfunction

  // Random item shaped to stay mostly legal: positions near the live range,
  // keys often taken from the list or a small pool so that hits and
  // duplicates are common. add_pct steers the list toward growing or shrinking.
  function automatic osst_pkg::osst_in_t random_item(input int add_pct);
    osst_pkg::osst_in_t it;
    int roll;
    int kroll;
    roll  = $urandom_range(99);
    kroll = $urandom_range(99);
    if (roll < add_pct) begin
      it.operation = ($urandom_range(1) == 0) ? osst_pkg::OP_APPEND
                                              : osst_pkg::OP_INSERT_AT;
    end else if (roll < 97) begin
      case ($urandom_range(3))
        0:       it.operation = osst_pkg::OP_REMOVE_AT;
        1:       it.operation = osst_pkg::OP_REMOVE_VALUE;
        2:       it.operation = osst_pkg::OP_READ_AT;
        default: it.operation = osst_pkg::OP_FIND;
      endcase
    end else if (roll == 97) begin
      it.operation = osst_pkg::OP_CLEAR;
    end else begin
      it.operation = OP_UNDEFINED;
    end
    if ($urandom_range(99) < 85)
      it.position = osst_pkg::POS_W'($urandom_range(shadow_count));
    else
      it.position = osst_pkg::POS_W'($urandom_range(63));
    if (kroll < 5)                            it.node_ref = '0;
    else if (kroll < 35)                      it.node_ref = key_pool[$urandom_range(7)];
    else if (kroll < 70 && shadow_count > 0)
      it.node_ref = list_shadow[$urandom_range(shadow_count - 1)];
    else                                      it.node_ref = $urandom();
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
    error_count++;
    $display("ERROR t=%0t result %0d: %s expected %0h got %0h",
             $time, results_seen, what, want_v, got_v);
  endtask

  // --------------------------------------------------------------------------
  // Input side: optional idle stretch, then hold valid until accepted.
  // The prediction is made at acceptance, in input order.
  // --------------------------------------------------------------------------
  task automatic send_item(input osst_pkg::osst_in_t it);
    osst_pkg::osst_out_t r;
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    r = apply_op(it);
    pending_results.push_back(r);
    status_tally[r.status]++;
    items_sent++;
  endtask

  task automatic send_op(input logic [osst_pkg::OP_W-1:0] op, input int pos,
                         input logic [osst_pkg::REF_W-1:0] key);
    osst_pkg::osst_in_t it;
    it.operation = op;
    it.position  = osst_pkg::POS_W'(pos);
    it.node_ref  = key;
    send_item(it);
  endtask

  // stop offering and wait until every predicted item has come back
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // register write; only called with the block idle
  task automatic write_dup_check(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dup_check_on = v;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready pattern, with a counted hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    osst_pkg::osst_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("item with nothing expected", 64'd0, 64'(out_item));
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(out_item.status));
        if (out_item.found_index !== want.found_index)
          report_mismatch("found_index", 64'(want.found_index),
                          64'(out_item.found_index));
        if (out_item.node_value !== want.node_value)
          report_mismatch("node_value", 64'(want.node_value),
                          64'(out_item.node_value));
        if (out_item.entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(want.entry_count),
                          64'(out_item.entry_count));
      end
    end
  end

  // watchdog: any stretch with no handshake on either side this long is a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no handshake for %0d cycles, %0d items outstanding",
               STALL_LIMIT, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // corner cases on a short list, checking on, no idling
  task automatic test_directed_ops();
    send_op(osst_pkg::OP_READ_AT, 0, '0);                   // empty list
    send_op(osst_pkg::OP_REMOVE_AT, 0, '0);
    send_op(osst_pkg::OP_FIND, 0, '0);                      // null never found
    send_op(osst_pkg::OP_APPEND, 0, '0);                    // null refused
    send_op(osst_pkg::OP_APPEND, 0, 32'hFFFF_FFFF);
    send_op(osst_pkg::OP_APPEND, 0, 32'h0000_0001);
    send_op(osst_pkg::OP_INSERT_AT, 0, 32'h8000_0000);      // shift everything up
    send_op(osst_pkg::OP_INSERT_AT, 3, 32'hA5A5_5A5A);      // position == count
    send_op(osst_pkg::OP_INSERT_AT, 5, 32'h1234_0000);      // above count
    send_op(osst_pkg::OP_INSERT_AT, 63, 32'h1234_0001);
    send_op(osst_pkg::OP_APPEND, 0, 32'hFFFF_FFFF);         // duplicate
    send_op(osst_pkg::OP_INSERT_AT, 1, 32'h0000_0001);      // duplicate via insert
    send_op(osst_pkg::OP_FIND, 0, 32'h0000_0001);
    send_op(osst_pkg::OP_FIND, 0, 32'h1234_5678);           // absent
    send_op(osst_pkg::OP_REMOVE_VALUE, 0, 32'h1234_5678);
    send_op(osst_pkg::OP_REMOVE_VALUE, 0, '0);
    send_op(osst_pkg::OP_READ_AT, 4, '0);                   // position == count
    send_op(osst_pkg::OP_READ_AT, 63, '0);
    send_op(osst_pkg::OP_READ_AT, 0, '0);
    send_op(osst_pkg::OP_REMOVE_AT, 3, '0);                 // top entry
    send_op(osst_pkg::OP_REMOVE_AT, 0, '0);                 // bottom entry
    send_op(osst_pkg::OP_REMOVE_VALUE, 0, 32'hFFFF_FFFF);
    send_op(OP_UNDEFINED, 0, 32'h0000_0001);
    send_op(osst_pkg::OP_CLEAR, 0, '0);
    send_op(osst_pkg::OP_FIND, 0, 32'h0000_0001);           // stale entry
    send_op(osst_pkg::OP_READ_AT, 0, '0);
    wait_idle();
  endtask

  // checking off: repeated keys, lowest position wins for find and remove
  task automatic test_duplicates_allowed();
    write_dup_check(1'b0);
    send_op(osst_pkg::OP_CLEAR, 0, '0);
    send_op(osst_pkg::OP_APPEND, 0, 32'hCAFE_0001);
    send_op(osst_pkg::OP_APPEND, 0, 32'hBEEF_0002);
    send_op(osst_pkg::OP_APPEND, 0, 32'hCAFE_0001);
    send_op(osst_pkg::OP_FIND, 0, 32'hCAFE_0001);
    send_op(osst_pkg::OP_REMOVE_VALUE, 0, 32'hCAFE_0001);
    send_op(osst_pkg::OP_FIND, 0, 32'hCAFE_0001);
    send_op(osst_pkg::OP_INSERT_AT, 0, 32'hBEEF_0002);
    send_op(osst_pkg::OP_READ_AT, 1, '0);
    send_op(osst_pkg::OP_REMOVE_VALUE, 0, 32'hBEEF_0002);
    send_op(osst_pkg::OP_APPEND, 0, '0);                    // null still refused
    wait_idle();
    write_dup_check(1'b1);
    send_op(osst_pkg::OP_APPEND, 0, 32'hCAFE_0001);         // now refused
    wait_idle();
  endtask

  // fill to DEPTH, then every add to the full list must report full unless refused earlier
  task automatic test_full_list();
    send_op(osst_pkg::OP_CLEAR, 0, '0);
    while (shadow_count < DEPTH) send_op(osst_pkg::OP_APPEND, 0, fresh_key());
    send_op(osst_pkg::OP_APPEND, 0, '0);                    // null beats full
    send_op(osst_pkg::OP_APPEND, 0, list_shadow[5]);        // duplicate beats full
    send_op(osst_pkg::OP_APPEND, 0, fresh_key());
    send_op(osst_pkg::OP_INSERT_AT, 33, fresh_key());       // bad position first
    send_op(osst_pkg::OP_INSERT_AT, DEPTH, fresh_key());
    send_op(osst_pkg::OP_INSERT_AT, 0, fresh_key());
    send_op(osst_pkg::OP_FIND, 0, list_shadow[DEPTH-1]);    // highest index
    send_op(osst_pkg::OP_READ_AT, DEPTH - 1, '0);
    send_op(osst_pkg::OP_READ_AT, DEPTH, '0);
    send_op(osst_pkg::OP_REMOVE_AT, DEPTH - 1, '0);
    send_op(osst_pkg::OP_INSERT_AT, DEPTH - 1, fresh_key());
    send_op(osst_pkg::OP_REMOVE_VALUE, 0, list_shadow[0]);
    send_op(osst_pkg::OP_INSERT_AT, 0, fresh_key());
    send_op(osst_pkg::OP_CLEAR, 0, '0);
    wait_idle();
  endtask

  // random traffic under one idling setting and one register value
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic dup_v, input int n_items);
    int i;
    write_dup_check(dup_v);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // alternate growing and shrinking stretches of the list
    for (i = 0; i < n_items; i++) send_item(random_item(((i / 40) % 2) ? 30 : 65));
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering: input must stall
  task automatic test_output_hold();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    for (i = 0; i < 40; i++) send_item(random_item(60));
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    shadow_count = 0;
    dup_check_on = 1'b1;  // register reset value
    foreach (list_shadow[i]) list_shadow[i] = '0;
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'h8000_0000;
    for (int i = 3; i < 8; i++) key_pool[i] = $urandom() | 32'h1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_duplicates_allowed();
    test_full_list();
    test_random_traffic(0, 0, 1'b1, 120);
    test_random_traffic(64, 0, 1'b0, 120);
    test_random_traffic(0, 64, 1'b1, 120);
    test_random_traffic(31, 31, 1'b0, 120);
    write_dup_check(1'b1);
    test_output_hold();

    // quiet window: anything arriving now was never expected
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    error_count += pending_results.size();

    $display("Covered %0d items / %0d results over directed, full-list, dup on/off,",
             items_sent, results_seen);
    $display("idling, hold-off; status done/refused/full = %0d/%0d/%0d",
             status_tally[osst_pkg::ST_DONE], status_tally[osst_pkg::ST_REJECT],
             status_tally[osst_pkg::ST_FULL]);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", error_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/osst_pkg.sv
hw/rtl/osst_cell.sv
hw/rtl/ordered_set_store.sv
test/tb_ordered_set_store.sv
